// ----- hdl/slt_pkg.sv -----
package slt_pkg;

   localparam int CHAR_W = 8;
   localparam int STAGE_W = 3;
   localparam int ARG_W = 4;
   localparam int LIMIT_W = 4;
   localparam int REDIR_W = 2;
   localparam int KIND_W = 3;
   localparam int DATA_W = 32;

   localparam logic [LIMIT_W-1:0] STAGE_SLOTS = 4'd8;
   localparam logic [ARG_W-1:0] ARG_LAST = 4'd15;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

   localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_HASH = 8'h23;
   localparam logic [CHAR_W-1:0] CH_PIPE = 8'h7C;
   localparam logic [CHAR_W-1:0] CH_GT = 8'h3E;
   localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
   localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;

   typedef enum logic [KIND_W-1:0] {
      KIND_SKIP   = 3'd0,
      KIND_TOKEN  = 3'd1,
      KIND_PATH   = 3'd2,
      KIND_STAGE  = 3'd3,
      KIND_REDIR  = 3'd4,
      KIND_DONE   = 3'd5
   } kind_type;

   typedef enum logic [REDIR_W-1:0] {
      REDIR_NONE     = 2'd0,
      REDIR_TRUNCATE = 2'd1,
      REDIR_APPEND   = 2'd2
   } redir_type;

   typedef enum logic [7:0] {
      MODE_BETWEEN = 8'b0000_0001,
      MODE_WORD    = 8'b0000_0010,
      MODE_QUOTED  = 8'b0000_0100,
      MODE_GT      = 8'b0000_1000,
      MODE_SKIP    = 8'b0001_0000,
      MODE_PATH    = 8'b0010_0000,
      MODE_COMMENT = 8'b0100_0000,
      MODE_FAILED  = 8'b1000_0000
   } mode_type;

   typedef struct packed {
      logic [6:0]         pad;
      logic               failed;
      logic [LIMIT_W-1:0] stage_count;
      logic [REDIR_W-1:0] redirect_mode;
      logic               arg_dropped;
      logic               token_closed;
      logic               token_start;
      logic [ARG_W-1:0]   arg;
      logic [STAGE_W-1:0] stage;
      logic [CHAR_W-1:0]  char_out;
   } rsp_data_type;

   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
   endfunction

endpackage

// ----- hdl/shell_line_tokenizer.sv -----
// channel | ports               | beat contents (lowest bit first)
// req     | req_tvalid/tready   | tdata: char_in[7:0]
// rsp     | rsp_tvalid/tready   | tdata: char_out .. failed (see port list), tuser: kind[2:0]
// csr     | csr_we              | csr_wdata: stage_limit[3:0]
// One byte per clock sustained while rsp_tready stays high; a req beat lands in the input
// register, and the whole scan step is one pass of logic from there to the result register.
// Synchronous reset clears the line state, empties both registers and sets stage_limit to 8.
// With rsp_tready low the result holds, one more byte waits in the input register,
// then req_tready drops until the result beat is taken.
module shell_line_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // char_in[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // char_out[7:0], stage[10:8], arg[14:11], token_start[15],
                                    // token_closed[16], arg_dropped[17], redirect_mode[19:18],
                                    // stage_count[23:20], failed[24], zero[31:25]
   output logic [2:0]  rsp_tuser,   // kind[2:0]
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata    // stage_limit[3:0]
);

   logic [slt_pkg::LIMIT_W-1:0] limit_ff;

   logic                        in_valid_ff;
   logic [slt_pkg::CHAR_W-1:0]  in_char_ff;
   logic                        out_valid_ff;
   slt_pkg::rsp_data_type       out_data_ff, out_data_in;
   slt_pkg::kind_type           out_kind_ff, out_kind_in;

   slt_pkg::mode_type           mode_ff, mode_in;
   logic                        quote_single_ff, quote_single_in;
   logic [slt_pkg::STAGE_W-1:0] stage_ff, stage_in;
   logic [slt_pkg::ARG_W-1:0]   arg_count_ff, arg_count_in;
   slt_pkg::redir_type          redir_ff, redir_in;
   logic [slt_pkg::ARG_W-1:0]   tok_index_ff, tok_index_in;
   logic                        tok_dropped_ff, tok_dropped_in;

   logic                        advance;
   logic [slt_pkg::LIMIT_W-1:0] eff_limit;
   logic [slt_pkg::LIMIT_W-1:0] stage_next;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_kind_ff;

   assign eff_limit  = (limit_ff > slt_pkg::STAGE_SLOTS) ? slt_pkg::STAGE_SLOTS : limit_ff;
   assign stage_next = {1'b0, stage_ff} + 4'd1;

   always_comb begin
      logic                       between;
      logic                       start;
      logic                       closed;
      slt_pkg::kind_type          kind;
      logic [slt_pkg::CHAR_W-1:0] ch;
      logic [slt_pkg::CHAR_W-1:0] c;

      c               = in_char_ff;
      between         = 1'b0;
      start           = 1'b0;
      closed          = 1'b0;
      kind            = slt_pkg::KIND_SKIP;
      ch              = slt_pkg::CH_NUL;
      mode_in         = mode_ff;
      quote_single_in = quote_single_ff;
      stage_in        = stage_ff;
      arg_count_in    = arg_count_ff;
      redir_in        = redir_ff;
      tok_index_in    = tok_index_ff;
      tok_dropped_in  = tok_dropped_ff;
      out_data_in     = '0;

      if (c == slt_pkg::CH_NUL) begin
         closed = (mode_ff == slt_pkg::MODE_WORD) || (mode_ff == slt_pkg::MODE_QUOTED) ||
                  (mode_ff == slt_pkg::MODE_GT) || (mode_ff == slt_pkg::MODE_SKIP) ||
                  (mode_ff == slt_pkg::MODE_PATH);
         out_data_in.failed        = (mode_ff == slt_pkg::MODE_FAILED);
         out_data_in.stage         = stage_ff;
         out_data_in.arg           = arg_count_ff;
         out_data_in.redirect_mode = redir_ff;
         out_data_in.token_closed  = closed;
         if (mode_ff != slt_pkg::MODE_FAILED && !(stage_ff == '0 && arg_count_ff == '0)) begin
            out_data_in.stage_count = stage_next;
         end
         kind            = slt_pkg::KIND_DONE;
         mode_in         = slt_pkg::MODE_BETWEEN;
         quote_single_in = 1'b0;
         stage_in        = '0;
         arg_count_in    = '0;
         redir_in        = slt_pkg::REDIR_NONE;
         tok_index_in    = '0;
         tok_dropped_in  = 1'b0;
      end else begin
         unique case (mode_ff)
            slt_pkg::MODE_WORD: begin
               if (slt_pkg::is_space(c)) begin
                  closed  = 1'b1;
                  mode_in = slt_pkg::MODE_BETWEEN;
               end else if (c == slt_pkg::CH_PIPE || c == slt_pkg::CH_GT) begin
                  closed  = 1'b1;
                  mode_in = slt_pkg::MODE_BETWEEN;
                  between = 1'b1;
               end else begin
                  kind = slt_pkg::KIND_TOKEN;
                  ch   = c;
               end
            end
            slt_pkg::MODE_QUOTED: begin
               if (c == (quote_single_ff ? slt_pkg::CH_SQUOTE : slt_pkg::CH_DQUOTE)) begin
                  closed  = 1'b1;
                  mode_in = slt_pkg::MODE_BETWEEN;
               end else begin
                  kind = slt_pkg::KIND_TOKEN;
                  ch   = c;
               end
            end
            slt_pkg::MODE_GT, slt_pkg::MODE_SKIP: begin
               if (mode_ff == slt_pkg::MODE_GT && c == slt_pkg::CH_GT) begin
                  redir_in = slt_pkg::REDIR_APPEND;
                  kind     = slt_pkg::KIND_REDIR;
                  mode_in  = slt_pkg::MODE_SKIP;
               end else if (c == slt_pkg::CH_SPACE || c == slt_pkg::CH_TAB) begin
                  mode_in = slt_pkg::MODE_SKIP;
               end else if (c == slt_pkg::CH_NEWLINE) begin
                  closed  = 1'b1;
                  mode_in = slt_pkg::MODE_BETWEEN;
               end else begin
                  kind    = slt_pkg::KIND_PATH;
                  ch      = c;
                  mode_in = slt_pkg::MODE_PATH;
               end
            end
            slt_pkg::MODE_PATH: begin
               if (slt_pkg::is_space(c)) begin
                  closed  = 1'b1;
                  mode_in = slt_pkg::MODE_BETWEEN;
               end else begin
                  kind = slt_pkg::KIND_PATH;
                  ch   = c;
               end
            end
            slt_pkg::MODE_COMMENT, slt_pkg::MODE_FAILED: begin
            end
            default: begin
               between = 1'b1;
            end
         endcase

         if (between) begin
            priority if (slt_pkg::is_space(c)) begin
            end else if (c == slt_pkg::CH_HASH) begin
               mode_in = slt_pkg::MODE_COMMENT;
            end else if (c == slt_pkg::CH_PIPE) begin
               kind = slt_pkg::KIND_STAGE;
               if (stage_next >= eff_limit) begin
                  mode_in = slt_pkg::MODE_FAILED;
               end else begin
                  stage_in     = stage_next[slt_pkg::STAGE_W-1:0];
                  arg_count_in = '0;
               end
            end else if (c == slt_pkg::CH_GT) begin
               kind     = slt_pkg::KIND_REDIR;
               redir_in = slt_pkg::REDIR_TRUNCATE;
               mode_in  = slt_pkg::MODE_GT;
            end else begin
               start          = 1'b1;
               tok_index_in   = arg_count_ff;
               tok_dropped_in = (arg_count_ff >= slt_pkg::ARG_LAST);
               if (arg_count_ff < slt_pkg::ARG_LAST) begin
                  arg_count_in = arg_count_ff + 4'd1;
               end
               if (c == slt_pkg::CH_DQUOTE || c == slt_pkg::CH_SQUOTE) begin
                  quote_single_in = (c == slt_pkg::CH_SQUOTE);
                  mode_in         = slt_pkg::MODE_QUOTED;
               end else begin
                  mode_in = slt_pkg::MODE_WORD;
                  kind    = slt_pkg::KIND_TOKEN;
                  ch      = c;
               end
            end
         end

         out_data_in.char_out      = ch;
         out_data_in.stage         = stage_in;
         out_data_in.token_start   = start;
         out_data_in.token_closed  = closed;
         out_data_in.redirect_mode = redir_in;
         out_data_in.failed        = (mode_in == slt_pkg::MODE_FAILED);
         if (kind == slt_pkg::KIND_TOKEN || start) begin
            out_data_in.arg         = tok_index_in;
            out_data_in.arg_dropped = tok_dropped_in;
         end else begin
            out_data_in.arg = arg_count_in;
         end
      end
      out_kind_in = kind;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff        <= slt_pkg::LIMIT_RESET;
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         mode_ff         <= slt_pkg::MODE_BETWEEN;
         quote_single_ff <= 1'b0;
         stage_ff        <= '0;
         arg_count_ff    <= '0;
         redir_ff        <= slt_pkg::REDIR_NONE;
         tok_index_ff    <= '0;
         tok_dropped_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff    <= 1'b1;
            mode_ff         <= mode_in;
            quote_single_ff <= quote_single_in;
            stage_ff        <= stage_in;
            arg_count_ff    <= arg_count_in;
            redir_ff        <= redir_in;
            tok_index_ff    <= tok_index_in;
            tok_dropped_ff  <= tok_dropped_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
         out_kind_ff <= out_kind_in;
      end
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= slt_pkg::KIND_DONE)
      else $error("result kind out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[23:20] != 4'd0 |-> rsp_tuser == slt_pkg::KIND_DONE
         && rsp_tdata[24] == 1'b0)
      else $error("stage count outside a finished line");

   assert property (@(posedge clock) disable iff (reset)
      advance && in_char_ff == slt_pkg::CH_NUL |=> mode_ff == slt_pkg::MODE_BETWEEN
         && stage_ff == '0 && arg_count_ff == '0 && redir_ff == slt_pkg::REDIR_NONE)
      else $error("line state not cleared at line end");

   assert property (@(posedge clock) disable iff (reset)
      mode_ff == slt_pkg::MODE_FAILED |-> stage_next >= eff_limit || $past(csr_we))
      else $error("failed line below stage limit");

   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("scanned byte produced no result");
`endif

endmodule

// ----- tb/shell_line_tokenizer_tb.sv -----
`timescale 1ns / 1ps

module shell_line_tokenizer_tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD = 40;
   localparam int PHASES = 6;
   localparam int PHASE_BYTES = 85;

   typedef struct {
      slt_pkg::kind_type     kind;
      slt_pkg::rsp_data_type data;
   } scan_result_type;

   typedef struct {
      bit                          is_write;
      logic [slt_pkg::CHAR_W-1:0]  value;
      bit                          pinned;
      slt_pkg::kind_type           kind;
      logic [slt_pkg::LIMIT_W-1:0] count;
      logic                        failed;
   } plan_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic csr_we = 1'b0;
   logic [3:0] csr_wdata = 4'd0;

   // tokenizer state as seen by the predictor
   slt_pkg::mode_type           scan_mode;
   logic                        in_squote;
   logic [slt_pkg::STAGE_W-1:0] cur_stage;
   logic [slt_pkg::ARG_W-1:0]   arg_total;
   slt_pkg::redir_type          redir;
   logic [slt_pkg::ARG_W-1:0]   tok_arg;
   logic                        tok_drop;
   logic [slt_pkg::LIMIT_W-1:0] limit_reg;

   scan_result_type            scan_results_due[$];
   plan_row_type               directed_plan[$];
   logic [slt_pkg::CHAR_W-1:0] line_bytes[$];

   int  mismatch_count = 0;
   int  idle_odds = 0;
   bit  long_hold_req = 1'b0;
   int  bytes_sent = 0;
   int  lines_sent = 0;
   int  limit_writes = 0;
   int  beats_checked = 0;
   int  drops_seen = 0;
   int  rejects_seen = 0;
   int  redirects_seen = 0;
   int  closes_seen = 0;

   shell_line_tokenizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void restart_line();
      scan_mode = slt_pkg::MODE_BETWEEN;
      in_squote = 1'b0;
      cur_stage = '0;
      arg_total = '0;
      redir = slt_pkg::REDIR_NONE;
      tok_arg = '0;
      tok_drop = 1'b0;
   endfunction

   function automatic scan_result_type scan_byte(input logic [slt_pkg::CHAR_W-1:0] c);
      scan_result_type r;
      logic at_gap;
      logic sep;
      logic [slt_pkg::LIMIT_W-1:0] lim;
      r.kind = slt_pkg::KIND_SKIP;
      r.data = '0;
      at_gap = (c == slt_pkg::CH_SPACE) || (c == slt_pkg::CH_TAB) ||
               (c == slt_pkg::CH_NEWLINE);
      sep = 1'b0;
      if (c == slt_pkg::CH_NUL) begin
         r.kind = slt_pkg::KIND_DONE;
         r.data.stage = cur_stage;
         r.data.arg = arg_total;
         r.data.redirect_mode = redir;
         r.data.token_closed = (scan_mode == slt_pkg::MODE_WORD) ||
                               (scan_mode == slt_pkg::MODE_QUOTED) ||
                               (scan_mode == slt_pkg::MODE_GT) ||
                               (scan_mode == slt_pkg::MODE_SKIP) ||
                               (scan_mode == slt_pkg::MODE_PATH);
         r.data.failed = (scan_mode == slt_pkg::MODE_FAILED);
         if (!r.data.failed && (cur_stage != '0 || arg_total != '0))
            r.data.stage_count = {1'b0, cur_stage} + 4'd1;
         restart_line();
         return r;
      end
      case (scan_mode)
         slt_pkg::MODE_WORD: begin
            if (at_gap || c == slt_pkg::CH_PIPE || c == slt_pkg::CH_GT) begin
               r.data.token_closed = 1'b1;
               scan_mode = slt_pkg::MODE_BETWEEN;
               sep = !at_gap;
            end else begin
               r.kind = slt_pkg::KIND_TOKEN;
               r.data.char_out = c;
            end
         end
         slt_pkg::MODE_QUOTED: begin
            if (c == (in_squote ? slt_pkg::CH_SQUOTE : slt_pkg::CH_DQUOTE)) begin
               r.data.token_closed = 1'b1;
               scan_mode = slt_pkg::MODE_BETWEEN;
            end else begin
               r.kind = slt_pkg::KIND_TOKEN;
               r.data.char_out = c;
            end
         end
         slt_pkg::MODE_GT, slt_pkg::MODE_SKIP: begin
            if (scan_mode == slt_pkg::MODE_GT && c == slt_pkg::CH_GT) begin
               redir = slt_pkg::REDIR_APPEND;
               r.kind = slt_pkg::KIND_REDIR;
               scan_mode = slt_pkg::MODE_SKIP;
            end else if (c == slt_pkg::CH_SPACE || c == slt_pkg::CH_TAB) begin
               scan_mode = slt_pkg::MODE_SKIP;
            end else if (c == slt_pkg::CH_NEWLINE) begin
               r.data.token_closed = 1'b1;
               scan_mode = slt_pkg::MODE_BETWEEN;
            end else begin
               r.kind = slt_pkg::KIND_PATH;
               r.data.char_out = c;
               scan_mode = slt_pkg::MODE_PATH;
            end
         end
         slt_pkg::MODE_PATH: begin
            if (at_gap) begin
               r.data.token_closed = 1'b1;
               scan_mode = slt_pkg::MODE_BETWEEN;
            end else begin
               r.kind = slt_pkg::KIND_PATH;
               r.data.char_out = c;
            end
         end
         slt_pkg::MODE_COMMENT, slt_pkg::MODE_FAILED: begin
         end
         default: sep = 1'b1;
      endcase
      if (sep && !at_gap) begin
         if (c == slt_pkg::CH_HASH) begin
            scan_mode = slt_pkg::MODE_COMMENT;
         end else if (c == slt_pkg::CH_PIPE) begin
            r.kind = slt_pkg::KIND_STAGE;
            lim = (limit_reg > slt_pkg::STAGE_SLOTS) ? slt_pkg::STAGE_SLOTS : limit_reg;
            if ({1'b0, cur_stage} + 4'd1 >= lim) begin
               scan_mode = slt_pkg::MODE_FAILED;
            end else begin
               cur_stage = cur_stage + 1'b1;
               arg_total = '0;
            end
         end else if (c == slt_pkg::CH_GT) begin
            r.kind = slt_pkg::KIND_REDIR;
            redir = slt_pkg::REDIR_TRUNCATE;
            scan_mode = slt_pkg::MODE_GT;
         end else begin
            if (c == slt_pkg::CH_DQUOTE || c == slt_pkg::CH_SQUOTE) begin
               in_squote = (c == slt_pkg::CH_SQUOTE);
               scan_mode = slt_pkg::MODE_QUOTED;
            end else begin
               scan_mode = slt_pkg::MODE_WORD;
               r.kind = slt_pkg::KIND_TOKEN;
               r.data.char_out = c;
            end
            r.data.token_start = 1'b1;
            tok_arg = arg_total;
            tok_drop = (arg_total >= slt_pkg::ARG_LAST);
            if (!tok_drop)
               arg_total = arg_total + 1'b1;
         end
      end
      r.data.stage = cur_stage;
      r.data.arg = arg_total;
      if (r.kind == slt_pkg::KIND_TOKEN || r.data.token_start) begin
         r.data.arg = tok_arg;
         r.data.arg_dropped = tok_drop;
      end
      r.data.redirect_mode = redir;
      r.data.failed = (scan_mode == slt_pkg::MODE_FAILED);
      return r;
   endfunction

   function automatic void add_step(input bit is_write,
                                    input logic [slt_pkg::CHAR_W-1:0] value,
                                    input bit pinned, input slt_pkg::kind_type kind,
                                    input logic [slt_pkg::LIMIT_W-1:0] count,
                                    input logic failed);
      plan_row_type row;
      row.is_write = is_write;
      row.value = value;
      row.pinned = pinned;
      row.kind = kind;
      row.count = count;
      row.failed = failed;
      directed_plan.push_back(row);
   endfunction

   function automatic logic [slt_pkg::CHAR_W-1:0] word_byte();
      logic [slt_pkg::CHAR_W-1:0] c;
      if ($urandom_range(0, 3) != 0)
         return 8'h61 + 8'($urandom_range(0, 25));
      do c = 8'($urandom_range(1, 255));
      while (c == slt_pkg::CH_SPACE || c == slt_pkg::CH_TAB || c == slt_pkg::CH_NEWLINE ||
             c == slt_pkg::CH_HASH || c == slt_pkg::CH_PIPE || c == slt_pkg::CH_GT ||
             c == slt_pkg::CH_DQUOTE || c == slt_pkg::CH_SQUOTE);
      return c;
   endfunction

   function automatic logic [slt_pkg::CHAR_W-1:0] blank_byte();
      case ($urandom_range(0, 3))
         0: return slt_pkg::CH_TAB;
         1: return slt_pkg::CH_NEWLINE;
         default: return slt_pkg::CH_SPACE;
      endcase
   endfunction

   function automatic void compose_line();
      int shape;
      int stages;
      int args;
      int s;
      int a;
      logic [slt_pkg::CHAR_W-1:0] q;
      logic [slt_pkg::CHAR_W-1:0] c;
      line_bytes.delete();
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
         repeat ($urandom_range(1, 20)) line_bytes.push_back(8'($urandom_range(1, 255)));
      end else begin
         stages = $urandom_range(1, (shape == 1) ? 9 : 3);
         for (s = 0; s < stages; s++) begin
            if (s != 0) begin
               if ($urandom_range(0, 1) == 1)
                  line_bytes.push_back(blank_byte());
               line_bytes.push_back(slt_pkg::CH_PIPE);
            end
            args = (shape == 2) ? $urandom_range(14, 19) : $urandom_range(0, 4);
            for (a = 0; a < args; a++) begin
               line_bytes.push_back(blank_byte());
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5: begin
                     repeat ($urandom_range(1, 4)) line_bytes.push_back(word_byte());
                  end
                  6, 7: begin
                     q = ($urandom_range(0, 1) == 1) ? slt_pkg::CH_SQUOTE : slt_pkg::CH_DQUOTE;
                     line_bytes.push_back(q);
                     repeat ($urandom_range(0, 3)) begin
                        do c = 8'($urandom_range(1, 255));
                        while (c == q);
                        line_bytes.push_back(c);
                     end
                     if ($urandom_range(0, 7) != 0)
                        line_bytes.push_back(q);
                  end
                  8: begin
                     line_bytes.push_back(slt_pkg::CH_GT);
                     if ($urandom_range(0, 1) == 1)
                        line_bytes.push_back(slt_pkg::CH_GT);
                     if ($urandom_range(0, 1) == 1)
                        line_bytes.push_back(slt_pkg::CH_SPACE);
                     repeat ($urandom_range(0, 3))
                        line_bytes.push_back(($urandom_range(0, 4) == 0) ?
                                             slt_pkg::CH_PIPE : word_byte());
                  end
                  default: line_bytes.push_back(8'($urandom_range(1, 255)));
               endcase
            end
         end
         if ($urandom_range(0, 7) == 0) begin
            line_bytes.push_back(slt_pkg::CH_HASH);
            repeat ($urandom_range(0, 5)) line_bytes.push_back(8'($urandom_range(1, 255)));
         end
      end
      line_bytes.push_back(slt_pkg::CH_NUL);
   endfunction

   function automatic void match_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic take_result(input logic [slt_pkg::KIND_W-1:0] kind_bits,
                              input slt_pkg::rsp_data_type got);
      scan_result_type want;
      if (scan_results_due.size() == 0) begin
         $error("result beat with no byte pending: kind %0d data %h", kind_bits, got);
         mismatch_count++;
      end else begin
         want = scan_results_due.pop_front();
         beats_checked++;
         drops_seen += want.data.arg_dropped;
         closes_seen += want.data.token_closed;
         if (want.kind == slt_pkg::KIND_REDIR)
            redirects_seen++;
         if (want.kind == slt_pkg::KIND_DONE && want.data.failed)
            rejects_seen++;
         match_field("kind", want.kind, kind_bits);
         match_field("char_out", want.data.char_out, got.char_out);
         match_field("stage", want.data.stage, got.stage);
         match_field("arg", want.data.arg, got.arg);
         match_field("token_start", want.data.token_start, got.token_start);
         match_field("token_closed", want.data.token_closed, got.token_closed);
         match_field("arg_dropped", want.data.arg_dropped, got.arg_dropped);
         match_field("redirect_mode", want.data.redirect_mode, got.redirect_mode);
         match_field("stage_count", want.data.stage_count, got.stage_count);
         match_field("failed", want.data.failed, got.failed);
         match_field("pad", 0, got.pad);
      end
   endtask

   task automatic send_char(input logic [slt_pkg::CHAR_W-1:0] c, input bit pinned,
                            input slt_pkg::kind_type pin_kind,
                            input logic [slt_pkg::LIMIT_W-1:0] pin_count,
                            input logic pin_failed);
      scan_result_type want;
      req_tvalid <= 1'b1;
      req_tdata <= c;
      do @(posedge clock);
      while (!req_tready);
      want = scan_byte(c);
      if (pinned) begin
         want.kind = pin_kind;
         want.data.stage_count = pin_count;
         want.data.failed = pin_failed;
      end
      scan_results_due.push_back(want);
      bytes_sent++;
      if (c == slt_pkg::CH_NUL)
         lines_sent++;
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (scan_results_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_limit(input logic [slt_pkg::LIMIT_W-1:0] value);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      limit_reg = value;
      limit_writes++;
   endtask

   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            take_result(rsp_tuser, rsp_tdata);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left = LONG_HOLD;
         end else if (stall_left == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            stall_left = $urandom_range(1, 5);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      logic [slt_pkg::LIMIT_W-1:0] phase_limit [PHASES];
      int phase_odds [PHASES];
      int phase_start;
      int phase;
      phase_limit = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd5, 4'd8};
      phase_odds = '{3, 0, 5, 2, 4, 0};
      phase_limit[4] = 4'($urandom_range(2, 7));
      restart_line();
      limit_reg = slt_pkg::LIMIT_RESET;

      add_step(1'b0, slt_pkg::CH_NUL,     1'b1, slt_pkg::KIND_DONE,  4'd0, 1'b0);
      add_step(1'b0, 8'h61,               1'b0, slt_pkg::KIND_SKIP,  4'd0, 1'b0);
      add_step(1'b0, 8'hFF,               1'b1, slt_pkg::KIND_TOKEN, 4'd0, 1'b0);
      add_step(1'b0, slt_pkg::CH_PIPE,    1'b1, slt_pkg::KIND_STAGE, 4'd0, 1'b0);
      add_step(1'b0, slt_pkg::CH_DQUOTE,  1'b0, slt_pkg::KIND_SKIP,  4'd0, 1'b0);
      add_step(1'b0, slt_pkg::CH_SQUOTE,  1'b1, slt_pkg::KIND_TOKEN, 4'd0, 1'b0);
      add_step(1'b0, slt_pkg::CH_DQUOTE,  1'b0, slt_pkg::KIND_SKIP,  4'd0, 1'b0);
      add_step(1'b0, 8'h62,               1'b0, slt_pkg::KIND_SKIP,  4'd0, 1'b0);
      add_step(1'b0, slt_pkg::CH_DQUOTE,  1'b1, slt_pkg::KIND_TOKEN, 4'd0, 1'b0);
      add_step(1'b0, slt_pkg::CH_GT,      1'b1, slt_pkg::KIND_REDIR, 4'd0, 1'b0);
      add_step(1'b0, slt_pkg::CH_GT,      1'b1, slt_pkg::KIND_REDIR, 4'd0, 1'b0);
      add_step(1'b0, slt_pkg::CH_GT,      1'b1, slt_pkg::KIND_PATH,  4'd0, 1'b0);
      add_step(1'b0, slt_pkg::CH_PIPE,    1'b1, slt_pkg::KIND_PATH,  4'd0, 1'b0);
      add_step(1'b0, slt_pkg::CH_TAB,     1'b0, slt_pkg::KIND_SKIP,  4'd0, 1'b0);
      add_step(1'b0, slt_pkg::CH_HASH,    1'b0, slt_pkg::KIND_SKIP,  4'd0, 1'b0);
      add_step(1'b0, 8'h78,               1'b1, slt_pkg::KIND_SKIP,  4'd0, 1'b0);
      add_step(1'b0, slt_pkg::CH_NUL,     1'b1, slt_pkg::KIND_DONE,  4'd2, 1'b0);
      add_step(1'b0, slt_pkg::CH_GT,      1'b0, slt_pkg::KIND_SKIP,  4'd0, 1'b0);
      add_step(1'b0, slt_pkg::CH_NEWLINE, 1'b0, slt_pkg::KIND_SKIP,  4'd0, 1'b0);
      add_step(1'b0, slt_pkg::CH_SQUOTE,  1'b0, slt_pkg::KIND_SKIP,  4'd0, 1'b0);
      add_step(1'b0, 8'h71,               1'b0, slt_pkg::KIND_SKIP,  4'd0, 1'b0);
      add_step(1'b0, slt_pkg::CH_NUL,     1'b1, slt_pkg::KIND_DONE,  4'd1, 1'b0);
      add_step(1'b1, 8'd1,                1'b0, slt_pkg::KIND_SKIP,  4'd0, 1'b0);
      add_step(1'b0, slt_pkg::CH_PIPE,    1'b1, slt_pkg::KIND_STAGE, 4'd0, 1'b1);
      add_step(1'b0, 8'h7A,               1'b1, slt_pkg::KIND_SKIP,  4'd0, 1'b1);
      add_step(1'b0, slt_pkg::CH_NUL,     1'b1, slt_pkg::KIND_DONE,  4'd0, 1'b1);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      idle_odds = 4;
      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_write)
            write_limit(directed_plan[i].value[slt_pkg::LIMIT_W-1:0]);
         else
            send_char(directed_plan[i].value, directed_plan[i].pinned, directed_plan[i].kind,
                      directed_plan[i].count, directed_plan[i].failed);
      end

      for (phase = 0; phase < PHASES; phase++) begin
         write_limit(phase_limit[phase]);
         idle_odds = phase_odds[phase];
         phase_start = bytes_sent;
         // hold the result side off while bytes keep coming, so the input backs up
         if (phase == 2)
            long_hold_req = 1'b1;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            compose_line();
            foreach (line_bytes[i])
               send_char(line_bytes[i], 1'b0, slt_pkg::KIND_SKIP, 4'd0, 1'b0);
         end
      end

      drain();
      repeat (4) @(posedge clock);
      $display("run covered %0d bytes in %0d lines, %0d stage-limit writes, %0d beats compared",
               bytes_sent, lines_sent, limit_writes, beats_checked);
      $display("  with %0d dropped-arg beats, %0d rejected lines, %0d redirects, %0d closes",
               drops_seen, rejects_seen, redirects_seen, closes_seen);
      if (mismatch_count == 0 && scan_results_due.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/slt_pkg.sv
hdl/shell_line_tokenizer.sv
tb/shell_line_tokenizer_tb.sv
